// File: design/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared forms for the concurrent checks of the design.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define ASSERT_SAME(name, clk, rst_n, trig, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define ASSERT_NEXT(name, clk, rst_n, trig, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// File: design/ffbs_pkg.sv
// ============================================================================
// ffbs_pkg
// Types, constants and helpers shared by the flip-dot frame serializer.
// ============================================================================
`default_nettype none

package ffbs_pkg;

    // Default size of the dot store.
    localparam int MAX_COLUMNS_DEF = 128;
    localparam int MAX_ROWS_DEF    = 16;

    // Operation codes of an input word.
    localparam logic [1:0] OP_PIXEL = 2'd0;
    localparam logic [1:0] OP_FILL  = 2'd1;
    localparam logic [1:0] OP_EMIT  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_DISPLAY_ADDRESS = 2'd0;
    localparam logic [1:0] REG_COLUMN_COUNT    = 2'd1;
    localparam logic [1:0] REG_ROW_COUNT       = 2'd2;
    localparam logic [1:0] REG_ROW_OFFSET      = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [3:0] DISPLAY_ADDRESS_RST = 4'd1;
    localparam logic [7:0] COLUMN_COUNT_RST    = 8'd96;
    localparam logic [4:0] ROW_COUNT_RST       = 5'd16;
    localparam logic [3:0] ROW_OFFSET_RST      = 4'd0;

    // Framing characters.
    localparam logic [7:0] CHR_STX   = 8'h02;
    localparam logic [7:0] CHR_ETX   = 8'h03;
    localparam logic [7:0] CHR_CMD   = 8'h31;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_UPPER = 8'h41;

    // Input word.
    typedef struct packed {
        logic [1:0] op;
        logic [6:0] pixel_x;
        logic [3:0] pixel_y;
        logic       dot_on;
    } t_in_word;

    // Output word.
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       frame_last;
    } t_out_word;

    // Uppercase ASCII hex digit of a nibble.
    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] w;
        w = {4'd0, v};
        if (v >= 4'd10) begin
            return w - 8'd10 + CHR_UPPER;
        end
        return w + CHR_ZERO;
    endfunction

endpackage

`default_nettype wire

// File: design/flipdot_frame_buffer_serializer.sv
// ============================================================================
// flipdot_frame_buffer_serializer
// Column-major flip-dot frame store with a hex ASCII serial frame generator.
// ============================================================================
// Pixel write: store read, then write back.
// Emit: store read, then the byte goes to the output register once it is free; no new word until then.
// Fill: one store entry written per cycle over the frame length.
// After reset a clearing pass writes zero to all MAX_COLUMNS*MAX_ROWS/8 entries;
// no input word is taken until it ends.
`default_nettype none

`include "assert_macros.svh"

module flipdot_frame_buffer_serializer #(
    parameter int MAX_COLUMNS = ffbs_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = ffbs_pkg::MAX_ROWS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Input words
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire ffbs_pkg::t_in_word i_in_word,
    // Output words
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output ffbs_pkg::t_out_word     o_out_word,
    // Configuration writes
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [7:0]         i_cfg_data
);

    localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS / 8;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LEN_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = $clog2(2 * DEPTH + 8);
    localparam int CMP_W  = (LEN_W > 11) ? LEN_W : 11;

    // Fixed frame positions.
    localparam logic [POS_W-1:0] POS_STX     = POS_W'(0);
    localparam logic [POS_W-1:0] POS_CMD     = POS_W'(1);
    localparam logic [POS_W-1:0] POS_ADDR    = POS_W'(2);
    localparam logic [POS_W-1:0] POS_LEN_HI  = POS_W'(3);
    localparam logic [POS_W-1:0] POS_LEN_LO  = POS_W'(4);
    localparam logic [POS_W-1:0] POS_PAYLOAD = POS_W'(5);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_FILL  = 5'b00100,
        ST_PIXEL = 5'b01000,
        ST_EMIT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [3:0] r_display_address;
    logic [7:0] r_column_count;
    logic [4:0] r_row_count;
    logic [3:0] r_row_offset;

    // Sequencer registers.
    logic [ADDR_W-1:0] r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_fill_last, n_fill_last;
    logic              r_fill_on, n_fill_on;
    logic [ADDR_W-1:0] r_pix_idx, n_pix_idx;
    logic [2:0]        r_pix_bit, n_pix_bit;
    logic              r_pix_on, n_pix_on;
    logic              r_pix_hit, n_pix_hit;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [7:0]        r_sum, n_sum;
    logic              r_out_valid, n_out_valid;
    ffbs_pkg::t_out_word r_out_word, n_out_word;

    // Store port signals.
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [7:0]        rd_data;

    // Derived frame geometry.
    logic [2:0]        groups;
    logic [10:0]       len_raw;
    logic [LEN_W-1:0]  len;
    logic [7:0]        len8;
    logic [POS_W-1:0]  pay_end;
    logic [4:0]        pix_y;
    logic [10:0]       pix_idx;
    logic              pix_hit;
    logic [POS_W-1:0]  emit_k;

    // Emit results.
    logic [7:0]        chk;
    logic [7:0]        emit_byte;
    logic              emit_last;
    logic              emit_sum;
    logic              out_free;
    logic              in_accept;

    // Byte groups per column and clamped frame length.
    always_comb begin
        groups  = 3'((6'(r_row_count) + 6'd7) >> 3);
        len_raw = 11'(r_column_count) * 11'(groups);
        if (CMP_W'(len_raw) > CMP_W'(DEPTH)) begin
            len = LEN_W'(DEPTH);
        end else begin
            len = LEN_W'(len_raw);
        end
        len8    = 8'(len);
        pay_end = POS_PAYLOAD + (POS_W'(len) << 1);
    end

    // Pixel index: full groups of the column plus the group of the offset row.
    always_comb begin
        pix_y   = 5'(i_in_word.pixel_y) + 5'(r_row_offset);
        pix_idx = 11'(groups) * 11'(i_in_word.pixel_x) + 11'(pix_y[4:3]);
        pix_hit = CMP_W'(pix_idx) < CMP_W'(len);
        emit_k  = r_pos - POS_PAYLOAD;
    end

    // Serial byte selection for the current frame position.
    always_comb begin
        chk       = 8'd0 - r_sum;
        emit_last = 1'b0;
        if (r_pos == POS_STX) begin
            emit_byte = ffbs_pkg::CHR_STX;
        end else if (r_pos == POS_CMD) begin
            emit_byte = ffbs_pkg::CHR_CMD;
        end else if (r_pos == POS_ADDR) begin
            emit_byte = ffbs_pkg::hex_digit(r_display_address);
        end else if (r_pos == POS_LEN_HI) begin
            emit_byte = ffbs_pkg::hex_digit(len8[7:4]);
        end else if (r_pos == POS_LEN_LO) begin
            emit_byte = ffbs_pkg::hex_digit(len8[3:0]);
        end else if (r_pos < pay_end) begin
            emit_byte = ffbs_pkg::hex_digit(emit_k[0] ? rd_data[3:0] : rd_data[7:4]);
        end else if (r_pos == pay_end) begin
            emit_byte = ffbs_pkg::CHR_ETX;
        end else if (r_pos == pay_end + POS_W'(1)) begin
            emit_byte = ffbs_pkg::hex_digit(chk[7:4]);
        end else begin
            emit_byte = ffbs_pkg::hex_digit(chk[3:0]);
            emit_last = 1'b1;
        end
        emit_sum = (r_pos != POS_STX) && (r_pos <= pay_end);
    end

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;

    // Main sequencer.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_fill_last = r_fill_last;
        n_fill_on   = r_fill_on;
        n_pix_idx   = r_pix_idx;
        n_pix_bit   = r_pix_bit;
        n_pix_on    = r_pix_on;
        n_pix_hit   = r_pix_hit;
        n_pos       = r_pos;
        n_sum       = r_sum;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        rd_en       = 1'b0;
        rd_addr     = r_pix_idx;
        wr_en       = 1'b0;
        wr_addr     = r_cnt;
        wr_data     = 8'd0;

        unique case (r_state)
            // Zero the whole store after reset.
            ST_CLEAR: begin
                wr_en = 1'b1;
                n_cnt = r_cnt + ADDR_W'(1);
                if (r_cnt == ADDR_W'(DEPTH - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end
            end
            // Take a word and start its store access.
            ST_IDLE: begin
                if (in_accept) begin
                    case (i_in_word.op)
                        ffbs_pkg::OP_PIXEL: begin
                            rd_en     = 1'b1;
                            rd_addr   = ADDR_W'(pix_idx);
                            n_pix_idx = ADDR_W'(pix_idx);
                            n_pix_bit = pix_y[2:0];
                            n_pix_on  = i_in_word.dot_on;
                            n_pix_hit = pix_hit;
                            n_state   = ST_PIXEL;
                        end
                        ffbs_pkg::OP_FILL: begin
                            n_cnt       = '0;
                            n_fill_last = ADDR_W'(len - LEN_W'(1));
                            n_fill_on   = i_in_word.dot_on;
                            if (len != '0) begin
                                n_state = ST_FILL;
                            end
                        end
                        ffbs_pkg::OP_EMIT: begin
                            rd_en   = 1'b1;
                            rd_addr = ADDR_W'(emit_k >> 1);
                            n_state = ST_EMIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // Write one frame entry per cycle.
            ST_FILL: begin
                wr_en   = 1'b1;
                wr_data = r_fill_on ? 8'hFF : 8'h00;
                n_cnt   = r_cnt + ADDR_W'(1);
                if (r_cnt == r_fill_last) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end
            end
            // Write back the byte with one dot changed, if the pixel lies inside the frame.
            ST_PIXEL: begin
                wr_en   = r_pix_hit;
                wr_addr = r_pix_idx;
                if (r_pix_on) begin
                    wr_data = rd_data | (8'd1 << r_pix_bit);
                end else begin
                    wr_data = rd_data & ~(8'd1 << r_pix_bit);
                end
                n_state = ST_IDLE;
            end
            // Deliver the serial byte once the output register is free.
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid           = 1'b1;
                    n_out_word.tx_byte    = emit_byte;
                    n_out_word.frame_last = emit_last;
                    if (emit_last) begin
                        n_pos = '0;
                        n_sum = '0;
                    end else begin
                        n_pos = r_pos + POS_W'(1);
                        if (emit_sum) begin
                            n_sum = r_sum + emit_byte;
                        end
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cnt       <= '0;
            r_pos       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pos       <= n_pos;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_fill_last <= n_fill_last;
        r_fill_on   <= n_fill_on;
        r_pix_idx   <= n_pix_idx;
        r_pix_bit   <= n_pix_bit;
        r_pix_on    <= n_pix_on;
        r_pix_hit   <= n_pix_hit;
        r_out_word  <= n_out_word;
    end

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_address <= ffbs_pkg::DISPLAY_ADDRESS_RST;
            r_column_count    <= ffbs_pkg::COLUMN_COUNT_RST;
            r_row_count       <= ffbs_pkg::ROW_COUNT_RST;
            r_row_offset      <= ffbs_pkg::ROW_OFFSET_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                ffbs_pkg::REG_DISPLAY_ADDRESS: r_display_address <= i_cfg_data[3:0];
                ffbs_pkg::REG_COLUMN_COUNT:    r_column_count    <= i_cfg_data;
                ffbs_pkg::REG_ROW_COUNT:       r_row_count       <= i_cfg_data[4:0];
                ffbs_pkg::REG_ROW_OFFSET:      r_row_offset      <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    ffbs_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // The frame end returns position and checksum to the frame start.
    `ASSERT_NEXT(a_frame_end_restart, i_clk, i_rst_n, (r_state == ST_EMIT) && out_free && emit_last, (r_pos == '0) && (r_sum == '0), "frame end did not restart the frame")

    // A pixel write back only touches entries inside the frame.
    `ASSERT_SAME(a_pixel_in_frame, i_clk, i_rst_n, (r_state == ST_PIXEL) && r_pix_hit, CMP_W'(r_pix_idx) < CMP_W'(len), "pixel write outside the frame")

    // A fill pass runs to its end and returns to idle.
    `ASSERT_NEXT(a_fill_continues, i_clk, i_rst_n, r_state == ST_FILL, (r_state == ST_FILL) || (r_state == ST_IDLE), "fill pass left its sequence")

endmodule

`default_nettype wire

// File: design/ffbs_store.sv
// ============================================================================
// ffbs_store
// Dot store: single-port write and registered read.
// ============================================================================
`default_nettype none

module ffbs_store #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [7:0]        i_wr_data,
    output logic      [7:0]        o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// ============================================================================
// tb_top
// Testbench for the flip-dot frame store and hex ASCII serializer.
// Words go in through a valid/stall port and registers through a valid/ready
// port. A model of the dot store, the frame position and the running checksum
// predicts every serial byte, and a checker process compares each output word
// with the oldest prediction. Directed tests cover the header, payload, ETX,
// checksum and the ignored pixel writes. Random phases then change the
// geometry, the idling of both sides and the back-pressure.
// ============================================================================
`default_nettype none

module tb_top;
    import ffbs_pkg::*;

    localparam int STORE_DEPTH  = MAX_COLUMNS_DEF * MAX_ROWS_DEF / 8;
    localparam int QUIET_CYCLES = STORE_DEPTH + 44;
    localparam int STALL_LIMIT  = 4000;
    localparam int SHOWN_ERRORS = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_word    i_in_word = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_word   o_out_word;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = REG_DISPLAY_ADDRESS;
    logic [7:0]  i_cfg_data = '0;

    // Mirror of the block's state.
    logic [7:0]  dot_mem [0:STORE_DEPTH-1];
    int unsigned frame_pos;
    logic [7:0]  chk_sum;
    logic [3:0]  cfg_addr;
    logic [7:0]  cfg_cols;
    logic [4:0]  cfg_rows;
    logic [3:0]  cfg_offs;

    // Serial bytes still owed by the block, oldest first.
    t_out_word   serial_due [$];

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          stall_hold = 0;
    int          mismatches = 0;
    int          words_taken = 0;
    int          bytes_checked = 0;
    int          frames_closed = 0;
    int          idle_cycles = 0;

    flipdot_frame_buffer_serializer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Frame model
    // ------------------------------------------------------------------
    function automatic logic [7:0] ascii_nibble(input logic [3:0] v);
        if (v >= 4'd10) begin
            return CHR_UPPER + 8'(v) - 8'd10;
        end
        return CHR_ZERO + 8'(v);
    endfunction

    function automatic int rows_padded();
        return (int'(cfg_rows) + 7) / 8 * 8;
    endfunction

    // Frame length in store bytes, clamped at the store depth.
    function automatic int frame_bytes();
        int n;
        n = int'(cfg_cols) * rows_padded() / 8;
        return (n > STORE_DEPTH) ? STORE_DEPTH : n;
    endfunction

    function automatic void model_reset();
        foreach (dot_mem[i]) dot_mem[i] = 8'h00;
        frame_pos = 0;
        chk_sum   = 8'h00;
        cfg_addr  = DISPLAY_ADDRESS_RST;
        cfg_cols  = COLUMN_COUNT_RST;
        cfg_rows  = ROW_COUNT_RST;
        cfg_offs  = ROW_OFFSET_RST;
    endfunction

    function automatic void model_reg_write(input logic [1:0] idx, input logic [7:0] val);
        case (idx)
            REG_DISPLAY_ADDRESS: cfg_addr = val[3:0];
            REG_COLUMN_COUNT:    cfg_cols = val;
            REG_ROW_COUNT:       cfg_rows = val[4:0];
            REG_ROW_OFFSET:      cfg_offs = val[3:0];
            default: ;
        endcase
    endfunction

    // Applies one accepted word and queues the serial byte an emit produces.
    function automatic void model_word(input t_in_word w);
        int          len;
        int          y;
        int          idx;
        int unsigned p;
        int unsigned pay_end;
        int unsigned k;
        logic [7:0]  len_lo;
        logic [7:0]  chk;
        logic [7:0]  store_val;
        t_out_word   res;

        len = frame_bytes();
        case (w.op)
            OP_PIXEL: begin
                y   = int'(w.pixel_y) + int'(cfg_offs);
                idx = (rows_padded() * int'(w.pixel_x) + y) / 8;
                if (idx < len) begin
                    dot_mem[idx][y % 8] = w.dot_on;
                end
            end
            OP_FILL: begin
                for (int i = 0; i < len; i++) begin
                    dot_mem[i] = w.dot_on ? 8'hFF : 8'h00;
                end
            end
            OP_EMIT: begin
                p       = frame_pos;
                pay_end = 5 + 2 * len;
                len_lo  = 8'(len);
                chk     = 8'h00 - chk_sum;
                res.frame_last = 1'b0;
                if (p == 0) begin
                    res.tx_byte = CHR_STX;
                end else if (p == 1) begin
                    res.tx_byte = CHR_CMD;
                end else if (p == 2) begin
                    res.tx_byte = ascii_nibble(cfg_addr);
                end else if (p == 3) begin
                    res.tx_byte = ascii_nibble(len_lo[7:4]);
                end else if (p == 4) begin
                    res.tx_byte = ascii_nibble(len_lo[3:0]);
                end else if (p < pay_end) begin
                    k         = p - 5;
                    store_val = dot_mem[(k >> 1) % STORE_DEPTH];
                    res.tx_byte = k[0] ? ascii_nibble(store_val[3:0])
                                       : ascii_nibble(store_val[7:4]);
                end else if (p == pay_end) begin
                    res.tx_byte = CHR_ETX;
                end else if (p == pay_end + 1) begin
                    res.tx_byte = ascii_nibble(chk[7:4]);
                end else begin
                    // Past the high checksum digit: the low digit closes the frame.
                    res.tx_byte    = ascii_nibble(chk[3:0]);
                    res.frame_last = 1'b1;
                end
                if (res.frame_last) begin
                    frame_pos = 0;
                    chk_sum   = 8'h00;
                end else begin
                    if (p >= 1 && p <= pay_end) begin
                        chk_sum = chk_sum + res.tx_byte;
                    end
                    frame_pos = p + 1;
                end
                serial_due.push_back(res);
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Offers one word from a falling edge until it is taken; returns on a falling edge.
    task automatic send_word(input t_in_word w);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        model_word(w);
        words_taken++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        model_reg_write(idx, val);
        @(negedge i_clk);
    endtask

    // Lets all owed bytes arrive and any fill finish, then sets the geometry.
    task automatic set_geometry(input logic [3:0] addr, input logic [7:0] cols,
                                input logic [4:0] rows, input logic [3:0] offs);
        i_in_valid <= 1'b0;
        while (serial_due.size() != 0) @(negedge i_clk);
        repeat (QUIET_CYCLES) @(negedge i_clk);
        write_reg(REG_DISPLAY_ADDRESS, 8'(addr));
        write_reg(REG_COLUMN_COUNT, cols);
        write_reg(REG_ROW_COUNT, 8'(rows));
        write_reg(REG_ROW_OFFSET, 8'(offs));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in_word make_word(input logic [1:0] op, input int x,
                                           input int y, input logic on);
        t_in_word w;
        w.op      = op;
        w.pixel_x = 7'(x);
        w.pixel_y = 4'(y);
        w.dot_on  = on;
        return w;
    endfunction

    // Mostly emits and pixels inside the frame, with some fills, no-ops and strays.
    function automatic t_in_word random_word();
        t_in_word w;
        int       pick;
        int       span;
        pick = $urandom_range(0, 99);
        span = (cfg_cols == 0) ? 1 : ((cfg_cols > 128) ? 128 : int'(cfg_cols));
        w.dot_on  = 1'($urandom_range(0, 1));
        w.pixel_y = 4'($urandom_range(0, 15));
        w.pixel_x = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                                : 7'($urandom_range(0, span - 1));
        if (pick < 55) begin
            w.op = OP_EMIT;
        end else if (pick < 90) begin
            w.op = OP_PIXEL;
        end else if (pick < 95) begin
            w.op = OP_FILL;
        end else begin
            w.op = OP_NOP;
        end
        return w;
    endfunction

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++) begin
            send_word(random_word());
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, or a forced hold-off while stall_hold runs.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (stall_hold > 0) begin
            i_out_stall <= 1'b1;
            stall_hold = stall_hold - 1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Checker: each output word against the oldest owed byte.
    // ------------------------------------------------------------------
    task automatic report_error(input string what, input t_out_word exp_w,
                                input t_out_word got_w);
        mismatches++;
        if (mismatches <= SHOWN_ERRORS) begin
            $display("ERROR %s: expected byte %h last %b, got byte %h last %b",
                     what, exp_w.tx_byte, exp_w.frame_last,
                     got_w.tx_byte, got_w.frame_last);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (serial_due.size() == 0) begin
                report_error("unexpected word", '0, o_out_word);
            end else begin
                exp_w = serial_due.pop_front();
                bytes_checked++;
                if (exp_w.frame_last) frames_closed++;
                if (o_out_word.tx_byte !== exp_w.tx_byte) begin
                    report_error("tx_byte", exp_w, o_out_word);
                end else if (o_out_word.frame_last !== exp_w.frame_last) begin
                    report_error("frame_last", exp_w, o_out_word);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run after too long without any handshake.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout after %0d cycles with no word moving", STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // One-byte frame: header, both payload digits, ETX and checksum digits.
    task automatic test_one_byte_frame();
        set_geometry(4'hF, 8'd1, 5'd1, 4'd0);
        send_word(make_word(OP_PIXEL, 0, 0, 1'b1));
        send_word(make_word(OP_PIXEL, 0, 7, 1'b1));
        send_word(make_word(OP_PIXEL, 0, 0, 1'b0));
        // Outside the frame, so the store must not change.
        send_word(make_word(OP_PIXEL, 127, 15, 1'b1));
        send_word(make_word(OP_PIXEL, 0, 15, 1'b1));
        send_word(make_word(OP_NOP, 127, 15, 1'b1));
        repeat (10) send_word(make_word(OP_EMIT, 0, 0, 1'b0));
    endtask

    // Fill with ones, then pixels that the row offset pushes to the column end and past the frame.
    task automatic test_fill_and_offset();
        set_geometry(4'h0, 8'd2, 5'd9, 4'd15);
        send_word(make_word(OP_FILL, 0, 0, 1'b1));
        send_word(make_word(OP_PIXEL, 0, 0, 1'b0));
        send_word(make_word(OP_PIXEL, 1, 15, 1'b1));
        repeat (6) send_word(make_word(OP_EMIT, 127, 15, 1'b1));
    endtask

    task automatic test_random_small_frames();
        set_geometry(4'($urandom_range(0, 15)), 8'd3, 5'($urandom_range(1, 16)),
                     4'($urandom_range(0, 15)));
        run_random(70);
    endtask

    // Zero columns and zero rows: an empty payload.
    task automatic test_empty_frame();
        set_geometry(4'hA, 8'd0, 5'd0, 4'd0);
        run_random(20);
    endtask

    // Length clamped at the store depth; the frame is left open on purpose so
    // that the next, shorter geometry finds the position past its checksum.
    task automatic test_oversize_frame();
        set_geometry(4'h5, 8'd255, 5'd31, 4'($urandom_range(0, 15)));
        run_random(60);
    endtask

    task automatic test_offset_spill();
        set_geometry(4'($urandom_range(0, 15)), 8'd2, 5'd8, 4'd15);
        run_random(60);
    endtask

    task automatic test_full_store();
        set_geometry(4'($urandom_range(0, 15)), 8'd128, 5'd16, 4'd0);
        run_random(40);
    endtask

    task automatic test_single_column();
        set_geometry(4'($urandom_range(0, 15)), 8'd1, 5'($urandom_range(0, 31)),
                     4'($urandom_range(0, 15)));
        run_random(80);
    endtask

    // The receiver holds off long enough that the block backs up into its input.
    task automatic test_backpressure();
        set_geometry(4'h3, 8'd4, 5'd16, 4'd0);
        stall_hold = 200;
        repeat (30) send_word(make_word(OP_EMIT, 0, 0, 1'b0));
        run_random(10);
    endtask

    initial begin
        model_reset();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct  = 18;
        recv_stall_pct = 60;
        test_one_byte_frame();
        test_fill_and_offset();
        test_random_small_frames();
        test_empty_frame();

        send_idle_pct  = 60;
        recv_stall_pct = 18;
        test_oversize_frame();
        test_offset_spill();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_full_store();
        test_single_column();
        test_backpressure();

        // Drain the last bytes and leave room for a trailing fill.
        i_in_valid <= 1'b0;
        while (serial_due.size() != 0) @(negedge i_clk);
        repeat (QUIET_CYCLES) @(negedge i_clk);

        $display("Run covered %0d input words and %0d serial bytes over %0d frames,",
                 words_taken, bytes_checked, frames_closed);
        $display("with empty, one-byte, clamped and full-store geometries and back-pressure.");
        if (mismatches == 0 && serial_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches, %0d bytes never seen", mismatches, serial_due.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
